@@ rtl/jwspt_pkg.sv @@
// Package for the jog wheel tracker: payload structs, mode and motor codes,
// register indexes and small helper functions. No dependencies.
`timescale 1ns / 1ps
package jwspt_pkg;

    localparam int MAX_PADDLE_SPAN_DEF = 1024;

    localparam logic [1:0] MODE_SPINNER = 2'd0;
    localparam logic [1:0] MODE_PADDLE  = 2'd1;
    localparam logic [1:0] MODE_WHEEL   = 2'd2;
    localparam logic [1:0] MODE_DIGITAL = 2'd3;

    localparam logic [1:0] DIR_NONE     = 2'd0;
    localparam logic [1:0] DIR_CW       = 2'd1;
    localparam logic [1:0] DIR_CCW      = 2'd2;
    localparam logic [1:0] DIR_OVERFLOW = 2'd3;

    localparam logic [1:0] MOTOR_NONE  = 2'd0;
    localparam logic [1:0] MOTOR_CW    = 2'd1;
    localparam logic [1:0] MOTOR_CCW   = 2'd2;
    localparam logic [1:0] MOTOR_BRAKE = 2'd3;

    localparam logic [2:0] REG_JOG_MODE    = 3'd0;
    localparam logic [2:0] REG_SPEED       = 3'd1;
    localparam logic [2:0] REG_FORCE       = 3'd2;
    localparam logic [2:0] REG_SPAN        = 3'd3;
    localparam logic [2:0] REG_SENSITIVITY = 3'd4;

    localparam int WHEEL_DEADZONE = 4;

    typedef struct packed {
        logic [7:0]  jog_position;
        logic [7:0]  jog_revolutions;
        logic [1:0]  jog_direction;
        logic [15:0] buttons_in;
    } jwspt_in_t;

    typedef struct packed {
        logic signed [7:0] spinner_delta;
        logic [7:0]        paddle_value;
        logic signed [7:0] stick_value;
        logic [15:0]       buttons_out;
        logic [1:0]        motor_direction;
        logic [3:0]        motor_force;
        logic              drop_revolutions;
        logic              report_changed;
    } jwspt_out_t;

    // Start and busy signals from the sequencer to the divider.
    typedef struct packed {
        logic start;
        logic busy;
    } jwspt_div_ctl_t;

    // Log2 of the spinner step for a speed code (16,8,4,2,1; codes above 4 use 4).
    function automatic logic [2:0] step_shift(input logic [2:0] speed);
        logic [2:0] r;
        begin
            case (speed)
                3'd0:    r = 3'd4;
                3'd1:    r = 3'd3;
                3'd3:    r = 3'd1;
                3'd4:    r = 3'd0;
                default: r = 3'd2;
            endcase
            return r;
        end
    endfunction

endpackage

@@ rtl/jwspt_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on jwspt_pkg.
`timescale 1ns / 1ps
module jwspt_div #(
    parameter int NUM_W = 19,
    parameter int DEN_W = 13
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  jwspt_pkg::jwspt_div_ctl_t ctl_in,
    input  logic [NUM_W-1:0]       numer,
    input  logic [DEN_W-1:0]       denom,
    output logic                   done,
    output logic [NUM_W-1:0]       quot
);
    import jwspt_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    always_comb
    begin
        trial = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl_in.start && !run_reg)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.start && !run_reg)
        begin
            q_reg   <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end
        else if (run_reg)
        begin
            if (!diff[DEN_W])
            begin
                rem_reg <= diff;
                q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_in.start && !run_reg) |=> run_reg)
        else $error("divider did not start");
    assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> !done_reg)
        else $error("done during run");
endmodule

@@ rtl/jog_wheel_spinner_paddle_tracker.sv @@
// Top level of the jog wheel tracker: APB registers, tracking state, sequencer.
// Depends on jwspt_pkg and jwspt_div.
`timescale 1ns / 1ps
//
//  channel   direction  handshake          payload
//  in        input      in_valid/in_stall  jwspt_in_t word
//  out       output     out_valid/out_stall jwspt_out_t word
//  apb       input      psel/penable/pready 32-bit registers at 4*i
//
// When the output is not stalled, a new word is accepted only once the previous
// one is through: the divider scales the paddle position to 0..255, the sequencer
// sees the divider finish, a finishing step loads the output register, the word
// is presented and taken, and then the input opens again. The tracking itself is
// done in the accept cycle.
// Reset clears all tracking state to its initial values at once.
// The input is stalled from acceptance until the result has been taken
// from the output register; a stalled output holds its word.
module jog_wheel_spinner_paddle_tracker #(
    parameter int MAX_PADDLE_SPAN = jwspt_pkg::MAX_PADDLE_SPAN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  jwspt_pkg::jwspt_in_t  in_word,
    output logic              out_valid,
    input  logic              out_stall,
    output jwspt_pkg::jwspt_out_t out_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import jwspt_pkg::*;

    localparam int SPAN_W = $clog2(MAX_PADDLE_SPAN + 1);
    // Widths of the scaling division's numerator (position*255 over span) and of the accumulator.
    localparam int NUM_W  = SPAN_W + 8;
    localparam int ACC_W  = 13;
    // Span in use right after reset; the paddle starts at its center.
    localparam int RESET_SPAN = (512 < MAX_PADDLE_SPAN) ? 512 : MAX_PADDLE_SPAN;

    typedef enum logic [1:0] { S_IDLE, S_DIV, S_OUT } state_t;

    // Configuration registers.
    logic [1:0]  mode_cfg_reg;
    logic [2:0]  speed_cfg_reg;
    logic [3:0]  force_cfg_reg;
    logic [10:0] span_cfg_reg;
    logic [1:0]  sens_cfg_reg;

    // Tracking state.
    logic [1:0]        applied_mode_reg;
    logic [1:0]        last_dir_reg;
    logic [15:0]       last_count_reg;
    logic [15:0]       clean_count_reg;
    logic [15:0]       reported_count_reg;
    logic [SPAN_W-1:0] paddle_pos_reg;
    logic signed [ACC_W-1:0] accum_reg;
    logic signed [6:0] pulse_reg;
    logic [15:0]       old_buttons_reg;
    logic [7:0]        old_paddle_reg;
    logic signed [7:0] old_spinner_reg;

    // Values held across the division.
    state_t            state_reg;
    logic [15:0]       nb_reg;
    logic signed [7:0] val_reg;
    logic signed [7:0] axis_reg;
    logic [1:0]        motor_reg;
    logic              drop_reg;
    logic [1:0]        mode_reg;
    logic [SPAN_W-1:0] span_reg;
    logic              out_valid_reg;
    jwspt_out_t        out_reg;

    wire wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_cfg_reg  <= MODE_SPINNER;
            speed_cfg_reg <= 3'd2;
            force_cfg_reg <= 4'd15;
            span_cfg_reg  <= 11'd512;
            sens_cfg_reg  <= 2'd1;
        end
        else if (wr_en)
        begin
            unique case (paddr[4:2])
                REG_JOG_MODE:    mode_cfg_reg  <= pwdata[1:0];
                REG_SPEED:       speed_cfg_reg <= pwdata[2:0];
                REG_FORCE:       force_cfg_reg <= pwdata[3:0];
                REG_SPAN:        span_cfg_reg  <= pwdata[10:0];
                REG_SENSITIVITY: sens_cfg_reg  <= pwdata[1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_JOG_MODE:    prdata = {30'd0, mode_cfg_reg};
            REG_SPEED:       prdata = {29'd0, speed_cfg_reg};
            REG_FORCE:       prdata = {28'd0, force_cfg_reg};
            REG_SPAN:        prdata = {21'd0, span_cfg_reg};
            REG_SENSITIVITY: prdata = {30'd0, sens_cfg_reg};
            default:         prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // Effective span, clamped to 2..MAX_PADDLE_SPAN.
    logic [SPAN_W-1:0] span_eff;
    always_comb
    begin
        if (span_cfg_reg < 11'd2)
            span_eff = SPAN_W'(2);
        else if ({21'd0, span_cfg_reg} > MAX_PADDLE_SPAN)
            span_eff = SPAN_W'(MAX_PADDLE_SPAN);
        else
            span_eff = SPAN_W'(span_cfg_reg);
    end
    wire [SPAN_W-1:0] half = span_eff >> 1;

    // Tracking computed in the accept cycle.
    logic [2:0]  sh;
    logic        mchg;
    logic [1:0]  dir_e;
    logic [1:0]  ldir_n;
    logic [15:0] newcnt;
    logic [15:0] lc_e, cc_e, rc_e;
    logic [15:0] cc_n;
    logic [15:0] dcnt;
    logic signed [ACC_W-1:0] acc_e, acc_n, acc_sum, acc_lim;
    logic signed [16:0] acc_wide;
    logic signed [16:0] sp;
    logic signed [16:0] hs;
    logic [SPAN_W-1:0] pp_n;
    logic [1:0]  motor;
    logic signed [15:0] diff;
    logic signed [15:0] bias;
    logic signed [15:0] q;
    logic signed [7:0]  val;
    logic [15:0] rc_n;
    logic signed [ACC_W-1:0] aq;
    logic signed [7:0]  axis_a;
    logic [15:0] nb;

    always_comb
    begin
        sh     = step_shift(speed_cfg_reg);
        mchg   = applied_mode_reg != mode_cfg_reg;
        dir_e  = in_word.jog_direction;
        newcnt = {in_word.jog_revolutions, in_word.jog_position};
        lc_e   = last_count_reg;
        cc_e   = clean_count_reg;
        rc_e   = reported_count_reg;
        if (dir_e == DIR_OVERFLOW)
        begin
            dir_e  = last_dir_reg;
            newcnt = (last_dir_reg == DIR_CW) ? 16'hFFFE : 16'h00FE;
            cc_e   = '0;
            rc_e   = '0;
        end
        ldir_n = (dir_e != DIR_NONE) ? dir_e : last_dir_reg;
        acc_e  = accum_reg;
        pp_n   = paddle_pos_reg;
        if (mchg)
        begin
            cc_e  = '0;
            rc_e  = '0;
            lc_e  = newcnt;
            pp_n  = half;
            acc_e = '0;
        end
        if (in_word.jog_direction == DIR_OVERFLOW && !mchg)
            lc_e = newcnt;
        dcnt    = newcnt - lc_e;
        cc_n    = cc_e;
        acc_n   = acc_e;
        acc_sum = acc_e + ACC_W'($signed(dcnt));
        acc_lim = ACC_W'(127) <<< sh;
        // The move counts as a signed 16-bit step; with the accumulator the sum
        // stays within 17 bits and in spinner mode is clamped to -128..127 spinner steps.
        acc_wide = $signed({{4{acc_e[ACC_W-1]}}, acc_e}) + $signed({dcnt[15], dcnt});
        if (dir_e != DIR_NONE)
        begin
            cc_n = cc_e + dcnt;
            if (mode_cfg_reg == MODE_SPINNER)
            begin
                if (acc_wide < -(17'sd128 <<< sh))
                    acc_n = -(ACC_W'(128) <<< sh);
                else if (acc_wide > (17'sd127 <<< sh))
                    acc_n = acc_lim;
                else
                    acc_n = acc_sum;
            end
        end
        sp = $signed({newcnt[15], newcnt});
        hs = $signed({1'b0, 16'(half)});
        motor = MOTOR_NONE;
        if (mode_cfg_reg == MODE_PADDLE || mode_cfg_reg == MODE_WHEEL)
        begin
            if (sp < -hs)
                pp_n = '0;
            else if (sp > hs)
                pp_n = span_eff;
            else
                pp_n = SPAN_W'(sp + hs);
        end
        if (mode_cfg_reg == MODE_PADDLE)
        begin
            if (sp < -hs || sp > hs)
                motor = MOTOR_BRAKE;
        end
        else if (mode_cfg_reg == MODE_WHEEL)
        begin
            if (sp < -17'sd4)
                motor = MOTOR_CW;
            else if (sp > 17'sd4)
                motor = MOTOR_CCW;
            else
                motor = MOTOR_BRAKE;
        end
        // Division by the power-of-two step, truncating toward zero.
        diff = $signed(cc_n - rc_e);
        bias = (diff < 0) ? $signed((16'd1 << sh) - 16'd1) : 16'sd0;
        q = (diff + bias) >>> sh;
        if (q > 16'sd127)
            val = 8'sd127;
        else if (q < -16'sd127)
            val = -8'sd127;
        else
            val = q[7:0];
        rc_n = rc_e + ({{8{val[7]}}, val} << sh);
        aq = (acc_n < 0) ? -((-acc_n) >>> sh) : (acc_n >>> sh);
        if (aq > ACC_W'(127))
            axis_a = 8'sd127;
        else if (aq < -ACC_W'(128))
            axis_a = -8'sd128;
        else
            axis_a = aq[7:0];
        nb = (in_word.buttons_in & 16'hFFFC) | {13'd0, in_word.buttons_in[0], 2'b00};
    end

    // Paddle scaling divider.
    jwspt_div_ctl_t div_ctl;
    logic           div_done;
    logic [NUM_W-1:0] div_q;
    wire in_acc = in_valid && !in_stall;
    assign div_ctl.start = in_acc;
    assign div_ctl.busy  = state_reg == S_DIV;

    jwspt_div #(.NUM_W(NUM_W), .DEN_W(SPAN_W)) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (div_ctl),
        .numer  (NUM_W'({pp_n, 8'd0} - {8'd0, pp_n})),
        .denom  (span_eff),
        .done   (div_done),
        .quot   (div_q)
    );

    // Finishing logic after the division.
    logic [7:0]        paddle;
    logic [15:0]       nb_f;
    logic signed [6:0] pt;
    logic signed [9:0] ax;
    logic signed [7:0] stick;
    logic              chg;
    always_comb
    begin
        if (mode_reg == MODE_SPINNER)
            paddle = 8'(axis_reg) + 8'h80;
        else if (div_q > NUM_W'(255))
            paddle = 8'hFF;
        else
            paddle = div_q[7:0];
        nb_f = nb_reg;
        pt   = pulse_reg;
        if (mode_reg == MODE_DIGITAL)
        begin
            if (val_reg < 0)
                pt = -7'sd64;
            else if (val_reg > 0)
                pt = 7'sd63;
            if (pt < 0)
                nb_f[0] = 1'b1;
            if (pt > 0)
                nb_f[1] = 1'b1;
        end
        chg = old_buttons_reg != nb_f || old_paddle_reg != paddle || old_spinner_reg != val_reg;
        ax = $signed({2'b00, paddle}) - 10'sd128;
        if (sens_cfg_reg == 2'd0)
            ax = (ax < 0) ? -((-ax) >>> 1) : (ax >>> 1);
        else if (sens_cfg_reg == 2'd2)
            ax = ax <<< 1;
        if (mode_reg == MODE_SPINNER)
            stick = axis_reg;
        else if (mode_reg == MODE_DIGITAL)
            stick = '0;
        else if (ax > 10'sd127)
            stick = 8'sd127;
        else if (ax < -10'sd128)
            stick = -8'sd128;
        else
            stick = ax[7:0];
        if (mode_reg == MODE_DIGITAL)
        begin
            if (pt < 0)
                pt = pt + 7'sd1;
            else if (pt > 0)
                pt = pt - 7'sd1;
        end
    end

    // Sequencer, tracking state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            applied_mode_reg   <= MODE_SPINNER;
            last_dir_reg       <= DIR_NONE;
            last_count_reg     <= '0;
            clean_count_reg    <= '0;
            reported_count_reg <= '0;
            paddle_pos_reg     <= SPAN_W'(RESET_SPAN / 2);
            accum_reg          <= '0;
            pulse_reg          <= '0;
            old_buttons_reg    <= 16'hFFFF;
            old_paddle_reg     <= 8'hFF;
            old_spinner_reg    <= -8'sd128;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        state_reg          <= S_DIV;
                        applied_mode_reg   <= mode_cfg_reg;
                        last_dir_reg       <= ldir_n;
                        last_count_reg     <= newcnt;
                        clean_count_reg    <= cc_n;
                        reported_count_reg <= rc_n;
                        paddle_pos_reg     <= pp_n;
                        accum_reg          <= acc_n;
                        if (mchg)
                        begin
                            old_buttons_reg <= 16'hFFFF;
                            old_paddle_reg  <= 8'hFF;
                            old_spinner_reg <= -8'sd128;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    pulse_reg <= pt;
                    if (chg)
                    begin
                        old_buttons_reg <= nb_f;
                        old_paddle_reg  <= paddle;
                        old_spinner_reg <= val_reg;
                    end
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_acc)
        begin
            nb_reg    <= nb;
            val_reg   <= val;
            axis_reg  <= axis_a;
            motor_reg <= motor;
            drop_reg  <= in_word.jog_direction == DIR_OVERFLOW;
            mode_reg  <= mode_cfg_reg;
            span_reg  <= span_eff;
        end
        if (state_reg == S_OUT)
        begin
            out_reg.spinner_delta    <= val_reg;
            out_reg.paddle_value     <= paddle;
            out_reg.stick_value      <= stick;
            out_reg.buttons_out      <= nb_f;
            out_reg.motor_direction  <= motor_reg;
            out_reg.motor_force      <= (motor_reg == MOTOR_NONE) ? 4'd0 :
                ((force_cfg_reg == 4'd1 || force_cfg_reg == 4'd3 || force_cfg_reg == 4'd7)
                 ? force_cfg_reg : 4'd15);
            out_reg.drop_revolutions <= drop_reg;
            out_reg.report_changed   <= chg;
        end
    end

    // Stalled until the output register is free and the sequencer is idle.
    assign in_stall  = state_reg != S_IDLE || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == S_DIV)
        else $error("accepted word did not start the sequence");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |=> out_valid_reg)
        else $error("finished word not presented");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input open while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> span_reg != '0)
        else $error("zero divisor");
endmodule
